// ===== hdl/mbrir_pkg.sv =====
// package for the modbus read-input-register client
// item, result and queue command types, codes and the crc-16 byte update
`default_nettype none

package mbrir_pkg;

  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  localparam logic       KIND_TX      = 1'b0;
  localparam logic       KIND_OUTCOME = 1'b1;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  QTY_HI          = 8'h00;
  localparam logic [7:0]  QTY_LO          = 8'h02;

  localparam logic [2:0] RX_LAST_DATA = 3'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] register_address;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [31:0] value_bits;
  } out_item_t;

  typedef struct packed {
    logic        is_outcome;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [1:0]  status;
    logic [31:0] value;
  } qcmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mbrir_fifo.sv =====
// short command queue between the front and back parts
// depends on mbrir_pkg for the command and status types
`default_nettype none

module mbrir_fifo
  import mbrir_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire qcmd_t        push_cmd,
  input  wire logic         pop,
  output qcmd_t             head,
  output fifo_status_t      status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qcmd_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  always_comb begin
    status.full  = (count == CNT_W'(DEPTH));
    status.empty = (count == '0);
    head         = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbrir_front.sv =====
// front part: accepts items, tracks the response and queues frame and outcome commands
// depends on mbrir_pkg for types, codes and the crc update
`default_nettype none

module mbrir_front
  import mbrir_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire in_item_t     item,
  input  wire logic [7:0]   slave_address,
  output logic              push,
  output qcmd_t             push_cmd
);

  logic        awaiting;
  logic        awaiting_next;
  logic [3:0]  bytes_received;
  logic [3:0]  bytes_received_next;
  logic [15:0] crc_acc;
  logic [15:0] crc_acc_next;
  logic        header_ok;
  logic        header_ok_next;
  logic [31:0] value_shift;
  logic [31:0] value_shift_next;
  logic [7:0]  crc_low;
  logic [7:0]  crc_low_next;
  logic        rx_clear;

  always_comb begin
    awaiting_next       = awaiting;
    bytes_received_next = bytes_received;
    crc_acc_next        = crc_acc;
    header_ok_next      = header_ok;
    value_shift_next    = value_shift;
    crc_low_next        = crc_low;
    rx_clear            = 1'b0;
    push                = 1'b0;
    push_cmd.is_outcome = KIND_OUTCOME;
    push_cmd.slave_addr = slave_address;
    push_cmd.reg_addr   = item.register_address;
    push_cmd.status     = STATUS_OK;
    push_cmd.value      = '0;
    if (accept) begin
      case (item.action)
        ACT_REQUEST: begin
          push                = 1'b1;
          push_cmd.is_outcome = KIND_TX;
          rx_clear            = 1'b1;
          awaiting_next       = 1'b1;
        end
        ACT_TIMEOUT: begin
          if (awaiting) begin
            push            = 1'b1;
            push_cmd.status = STATUS_SHORT;
            rx_clear        = 1'b1;
            awaiting_next   = 1'b0;
          end
        end
        ACT_BYTE: begin
          if (awaiting) begin
            if (bytes_received < 4'(RX_LAST_DATA)) begin
              crc_acc_next = crc_update(crc_acc, item.rx_byte);
              if (bytes_received == 4'd0 && item.rx_byte != slave_address) begin
                header_ok_next = 1'b0;
              end
              if (bytes_received == 4'd1 && item.rx_byte != FUNC_READ_INPUT) begin
                header_ok_next = 1'b0;
              end
              if (bytes_received >= 4'd3) begin
                value_shift_next = {value_shift[23:0], item.rx_byte};
              end
              bytes_received_next = bytes_received + 1'b1;
            end else if (bytes_received == 4'(RX_LAST_DATA)) begin
              crc_low_next        = item.rx_byte;
              bytes_received_next = bytes_received + 1'b1;
            end else begin
              push = 1'b1;
              if (({item.rx_byte, crc_low} == crc_acc) && header_ok) begin
                push_cmd.status = STATUS_OK;
                push_cmd.value  = value_shift;
              end else begin
                push_cmd.status = STATUS_MISMATCH;
              end
              rx_clear      = 1'b1;
              awaiting_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (rx_clear) begin
      bytes_received_next = '0;
      crc_acc_next        = CRC_INIT;
      header_ok_next      = 1'b1;
      value_shift_next    = '0;
      crc_low_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting       <= 1'b0;
      bytes_received <= '0;
      crc_acc        <= CRC_INIT;
      header_ok      <= 1'b1;
      value_shift    <= '0;
      crc_low        <= '0;
    end else begin
      awaiting       <= awaiting_next;
      bytes_received <= bytes_received_next;
      crc_acc        <= crc_acc_next;
      header_ok      <= header_ok_next;
      value_shift    <= value_shift_next;
      crc_low        <= crc_low_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbrir_back.sv =====
// back part: turns queued commands into frame bytes and outcomes in an output register
// depends on mbrir_pkg for types, codes and the crc update
`default_nettype none

module mbrir_back
  import mbrir_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire qcmd_t         head,
  input  wire fifo_status_t  fifo_status,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output out_item_t          result
);

  logic        active;
  logic        active_next;
  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  addr;
  logic [15:0] reg_addr;
  logic        advance;
  logic        load;
  logic [7:0]  frame_byte;
  out_item_t   result_next;
  logic        valid_next;

  always_comb begin
    case (idx)
      3'd0:    frame_byte = addr;
      3'd1:    frame_byte = FUNC_READ_INPUT;
      3'd2:    frame_byte = reg_addr[15:8];
      3'd3:    frame_byte = reg_addr[7:0];
      3'd4:    frame_byte = QTY_HI;
      3'd5:    frame_byte = QTY_LO;
      3'd6:    frame_byte = crc[7:0];
      default: frame_byte = crc[15:8];
    endcase
  end

  always_comb begin
    advance     = !result_valid || !result_stall;
    pop         = advance && !active && !fifo_status.empty;
    load        = pop && !head.is_outcome;
    active_next = active;
    idx_next    = idx;
    crc_next    = crc;
    valid_next  = result_valid;
    result_next = result;
    if (advance) begin
      valid_next = 1'b0;
      if (active) begin
        valid_next             = 1'b1;
        result_next.kind       = KIND_TX;
        result_next.tx_byte    = frame_byte;
        result_next.last       = (idx == 3'd7);
        result_next.status     = STATUS_OK;
        result_next.value_bits = '0;
        // crc covers the six header bytes only
        if (idx < 3'd6) begin
          crc_next = crc_update(crc, frame_byte);
        end
        idx_next               = idx + 1'b1;
        if (idx == 3'd7) begin
          active_next = 1'b0;
        end
      end else if (pop) begin
        valid_next = 1'b1;
        if (head.is_outcome) begin
          result_next.kind       = KIND_OUTCOME;
          result_next.tx_byte    = '0;
          result_next.last       = 1'b1;
          result_next.status     = head.status;
          result_next.value_bits = head.value;
        end else begin
          result_next.kind       = KIND_TX;
          result_next.tx_byte    = head.slave_addr;
          result_next.last       = 1'b0;
          result_next.status     = STATUS_OK;
          result_next.value_bits = '0;
          crc_next               = crc_update(CRC_INIT, head.slave_addr);
          idx_next               = 3'd1;
          active_next            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      active       <= active_next;
      idx          <= idx_next;
      result_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    crc    <= crc_next;
    result <= result_next;
    if (load) begin
      addr     <= head.slave_addr;
      reg_addr <= head.reg_addr;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/modbus_read_input_register_client_core.sv =====
// top level of the modbus rtu read-input-register client
// depends on mbrir_pkg, mbrir_front, mbrir_fifo and mbrir_back
`default_nettype none

// The block takes one request every cycle while its command queue has room.
// A read request becomes eight frame bytes on the result side, one per cycle
// unless stalled, the crc built byte by byte as the frame goes out, so it
// holds the back part for all eight bytes; a timeout or the ninth response
// byte becomes one outcome, loaded into the output register as it leaves the
// queue. Response bytes are checked in the front part as they arrive, one
// crc byte update each cycle. Requests stall only when QUEUE_DEPTH commands
// wait for the output side. The slave address register sits at byte address 0.

module modbus_read_input_register_client_core
  import mbrir_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire in_item_t     item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output out_item_t         result,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic         [7:0] slave_address;
  logic               accept;
  logic               push;
  qcmd_t              push_cmd;
  logic               pop;
  qcmd_t              head;
  fifo_status_t       fifo_status;

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? {24'h000000, slave_address} : 32'h0;
  assign item_stall = fifo_status.full;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'h01;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      slave_address <= pwdata[7:0];
    end
  end

  mbrir_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .slave_address (slave_address),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  mbrir_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (fifo_status)
  );

  mbrir_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .fifo_status  (fifo_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== tb/modbus_read_input_register_client_core_tb.sv =====
// self-checking testbench for modbus_read_input_register_client_core
// predicts request frames and read outcomes, checks them in order; needs mbrir_pkg
`timescale 1ns / 1ps

module modbus_read_input_register_client_core_tb;
  import mbrir_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_SLAVE = 3'd0;
  localparam logic [7:0] BYTE_COUNT = 8'h04;

  typedef enum int {FLAW_NONE, FLAW_ADDR, FLAW_FUNC, FLAW_CRC, FLAW_DATA} flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  modbus_read_input_register_client_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // request stimulus and the replies it should produce
  in_item_t  request_q[$];
  out_item_t owed_replies[$];
  out_item_t due;

  // client shadow state
  logic [7:0]  slave_cfg = 8'd1;
  logic        waiting = 1'b0;
  logic [3:0]  rx_count = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic        hdr_good = 1'b1;
  logic [31:0] rx_value = '0;
  logic [7:0]  rx_crc_lo = '0;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int err_count = 0;
  int n_requests = 0;
  int n_tx_bytes = 0;
  int n_ok = 0;
  int n_short = 0;
  int n_bad = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
    end
    return c;
  endfunction

  task automatic clear_rx();
    rx_count = '0;
    rx_crc = CRC_INIT;
    hdr_good = 1'b1;
    rx_value = '0;
    rx_crc_lo = '0;
  endtask

  task automatic predict_client(input in_item_t it);
    logic [7:0]  fr [0:7];
    logic [15:0] c;
    case (it.action)
      ACT_REQUEST: begin
        fr[0] = slave_cfg;
        fr[1] = FUNC_READ_INPUT;
        fr[2] = it.register_address[15:8];
        fr[3] = it.register_address[7:0];
        fr[4] = QTY_HI;
        fr[5] = QTY_LO;
        c = CRC_INIT;
        for (int i = 0; i < 6; i++) c = crc16_step(c, fr[i]);
        fr[6] = c[7:0];
        fr[7] = c[15:8];
        for (int i = 0; i < 8; i++) begin
          owed_replies.push_back(out_item_t'{KIND_TX, fr[i], (i == 7), STATUS_OK, 32'd0});
        end
        n_requests++;
        clear_rx();
        waiting = 1'b1;
      end
      ACT_TIMEOUT: begin
        if (waiting) begin
          owed_replies.push_back(out_item_t'{KIND_OUTCOME, 8'd0, 1'b1, STATUS_SHORT, 32'd0});
          waiting = 1'b0;
          clear_rx();
        end
      end
      ACT_BYTE: begin
        if (waiting) begin
          if (rx_count < 4'd7) begin
            rx_crc = crc16_step(rx_crc, it.rx_byte);
            if (rx_count == 4'd0 && it.rx_byte != slave_cfg) hdr_good = 1'b0;
            if (rx_count == 4'd1 && it.rx_byte != FUNC_READ_INPUT) hdr_good = 1'b0;
            if (rx_count >= 4'd3) rx_value = {rx_value[23:0], it.rx_byte};
            rx_count++;
          end else if (rx_count == 4'd7) begin
            rx_crc_lo = it.rx_byte;
            rx_count++;
          end else begin
            if ({it.rx_byte, rx_crc_lo} == rx_crc && hdr_good) begin
              owed_replies.push_back(out_item_t'{KIND_OUTCOME, 8'd0, 1'b1, STATUS_OK, rx_value});
            end else begin
              owed_replies.push_back(out_item_t'{KIND_OUTCOME, 8'd0, 1'b1, STATUS_MISMATCH, 32'd0});
            end
            waiting = 1'b0;
            clear_rx();
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_client(item);
      end
      if (!item_valid || !item_stall) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          item <= request_q.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (owed_replies.size() == 0) begin
        err_count++;
        $display("%0t: result expected none got %p", $time, result);
      end else begin
        due = owed_replies.pop_front();
        check_field("kind", due.kind, result.kind);
        check_field("tx_byte", due.tx_byte, result.tx_byte);
        check_field("last", due.last, result.last);
        check_field("status", due.status, result.status);
        check_field("value_bits", due.value_bits, result.value_bits);
        if (due.kind == KIND_TX) n_tx_bytes++;
        else if (due.status == STATUS_OK) n_ok++;
        else if (due.status == STATUS_SHORT) n_short++;
        else n_bad++;
      end
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [15:0] ra, input logic [7:0] rb);
    request_q.push_back(in_item_t'{act, ra, rb});
  endtask

  // response frame addressed to the current slave, first n bytes queued
  task automatic push_response(input int n, input flaw_t fl, input logic [31:0] v);
    logic [7:0]  fr [0:8];
    logic [15:0] c;
    fr[0] = slave_cfg;
    fr[1] = FUNC_READ_INPUT;
    fr[2] = BYTE_COUNT;
    {fr[3], fr[4], fr[5], fr[6]} = v;
    if (fl == FLAW_ADDR) fr[0] ^= 8'($urandom_range(1, 255));
    if (fl == FLAW_FUNC) fr[1] ^= 8'($urandom_range(1, 255));
    c = CRC_INIT;
    for (int i = 0; i < 7; i++) c = crc16_step(c, fr[i]);
    fr[7] = c[7:0];
    fr[8] = c[15:8];
    if (fl == FLAW_CRC) fr[$urandom_range(8, 7)] ^= 8'($urandom_range(1, 255));
    if (fl == FLAW_DATA) fr[$urandom_range(6, 2)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < n; i++) push_item(ACT_BYTE, 16'($urandom), fr[i]);
  endtask

  task automatic queue_exchanges(input int target);
    int made;
    int pick;
    int k;
    flaw_t fl;
    logic [31:0] v;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < 88) push_item(ACT_REQUEST, 16'($urandom), 8'($urandom));
      if (pick < 55) begin
        fl = ($urandom_range(9) < 6) ? FLAW_NONE : flaw_t'($urandom_range(FLAW_DATA, FLAW_ADDR));
        v = $urandom;
        if ($urandom_range(15) == 0) v = '1;
        else if ($urandom_range(15) == 0) v = '0;
        push_response(9, fl, v);
        made += 10;
      end else if (pick < 70) begin
        k = $urandom_range(8);
        push_response(k, FLAW_NONE, $urandom);
        push_item(ACT_TIMEOUT, 16'($urandom), 8'($urandom));
        made += k + 2;
      end else if (pick < 80) begin
        k = $urandom_range(8);
        push_response(k, FLAW_NONE, $urandom);
        made += k + 1;
      end else if (pick < 88) begin
        push_item(ACT_TIMEOUT, 16'($urandom), 8'($urandom));
        made += 2;
      end else begin
        push_item(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (request_q.size() > 0 || item_valid || owed_replies.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  // write the slave address, then read it back
  task automatic program_slave_address(input logic [7:0] a);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SLAVE;
    pwdata <= {24'd0, a};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[7:0] !== a) begin
      err_count++;
      $display("%0t: slave_address readback expected %h got %h", $time, a, prdata[7:0]);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    slave_cfg = a;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_pct = 36;
    recv_stall_pct = 66;
    push_item(ACT_BYTE, 16'h0000, 8'hFF);
    push_item(ACT_TIMEOUT, 16'hFFFF, 8'h00);
    push_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
    push_item(ACT_REQUEST, 16'h0000, 8'h00);
    push_response(9, FLAW_NONE, 32'hFFFF_FFFF);
    push_item(ACT_REQUEST, 16'hFFFF, 8'hFF);
    push_response(9, FLAW_CRC, 32'h0000_0000);
    push_item(ACT_REQUEST, 16'h8001, 8'h55);
    push_item(ACT_REQUEST, 16'h7FFE, 8'hAA);
    push_item(ACT_TIMEOUT, 16'h0000, 8'h00);
    wait_quiet();

    program_slave_address(8'h00);
    queue_exchanges(100);
    wait_quiet();

    // address changes between a request and its response
    push_item(ACT_REQUEST, 16'($urandom), 8'($urandom));
    wait_quiet();
    program_slave_address(8'hFF);
    push_response(9, FLAW_NONE, $urandom);
    wait_quiet();

    send_gap_pct = 66;
    recv_stall_pct = 36;
    queue_exchanges(100);
    wait_quiet();

    program_slave_address(8'($urandom_range(254, 1)));
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    queue_exchanges(100);
    wait_quiet();

    if (owed_replies.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, owed_replies.size());
    end
    $display("run covered %0d read requests, %0d frame bytes, outcomes %0d ok, %0d short, %0d bad",
             n_requests, n_tx_bytes, n_ok, n_short, n_bad);
    $display("slave addresses 1, 0x00, 0xff and one random; idling both ways and a long hold-off");
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
